>>> rtl/core/csim_pkg.sv
// ---------------------------------------------------------------------------
// Cosine similarity package
// Word types, sequencer states, long-multiply operations and accumulator
// limits shared by the cosine similarity stream block.
// ---------------------------------------------------------------------------
package csim_pkg;

  localparam int unsigned LimbW    = 32;
  localparam int unsigned AccW     = 48;
  localparam int unsigned ResBits  = 15;
  localparam logic [3:0]  TopBit   = 4'(ResBits - 1);

  localparam logic [AccW-1:0] DotMax  = {1'b0, {(AccW-1){1'b1}}};
  localparam logic [AccW-1:0] DotMin  = {1'b1, {(AccW-1){1'b0}}};
  localparam logic [AccW-1:0] NormMax = {AccW{1'b1}};

  typedef logic [LimbW-1:0]   limb_t;
  typedef logic [2*LimbW-1:0] prod_t;

  typedef struct packed {
    logic signed [15:0] a_value;
    logic signed [15:0] b_value;
    logic               last;
  } in_t;

  typedef struct packed {
    logic signed [15:0] similarity;
    logic               zero_norm;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DOT_MUL,
    ST_DOT_ADD,
    ST_NA_ADD,
    ST_NB_ADD,
    ST_FIN,
    ST_MUL_ISSUE,
    ST_MUL_ADD,
    ST_MUL_DONE,
    ST_CMP,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    OP_P,
    OP_D2,
    OP_K,
    OP_L
  } mop_e;

endpackage

>>> rtl/core/csim_mul.sv
// ---------------------------------------------------------------------------
// Shared limb multiplier
// Unsigned 32x32 multiplier with a registered 64-bit product, reused for
// the element products and every limb of the final long multiplications.
// ---------------------------------------------------------------------------
module csim_mul import csim_pkg::*; (
  input  logic  clk_i,
  input  limb_t op_a_i,
  input  limb_t op_b_i,
  output prod_t prod_o
);

  prod_t prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_t'(op_a_i) * prod_t'(op_b_i);
  end

  assign prod_o = prod_q;

endmodule

>>> rtl/core/csim_seq.sv
// ---------------------------------------------------------------------------
// Cosine similarity sequencer
// Accumulates dot product and squared norms, then finds the rounded Q1.15
// cosine bit by bit with exact long multiplications on the shared unit.
// ---------------------------------------------------------------------------
module csim_seq import csim_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  in_t   in_data_i,
  output logic  res_valid_o,
  input  logic  res_ready_i,
  output out_t  res_o,
  output limb_t mul_a_o,
  output limb_t mul_b_o,
  input  prod_t mul_prod_i
);

  state_e state_q, state_d;
  mop_e   op_q;

  logic [15:0]     a_mag_q, b_mag_q;
  logic            neg_ab_q, last_q;
  logic [AccW-1:0] dot_q, na_q, nb_q, mag_q;
  logic            neg_q;
  logic            i_q;
  logic [1:0]      j_q;
  limb_t           carry_q, kk_q;
  limb_t [3:0]     acc_q;
  limb_t [2:0]     p_q;
  limb_t [3:0]     r_q;
  logic [ResBits-1:0] c_q;
  logic [3:0]      bit_q;
  logic            borrow_q;
  out_t            res_q;

  logic            x_last;
  logic [1:0]      y_last;
  limb_t           x_limb, y_limb, p_sel;
  logic [ResBits-1:0] cand, c_new;
  logic [15:0]     k_val;
  logic [1:0]      idx, idx1;
  prod_t           t_sum;
  logic [LimbW:0]  diff;
  logic [49:0]     term, sterm, dsum;
  logic [AccW:0]   nsum_a, nsum_b;
  logic [AccW-1:0] dot_next, na_next, nb_next;
  logic            zero_in, cmp_end;

  assign cand  = c_q | (ResBits'(1) << bit_q);
  assign k_val = {cand, 1'b0} - 16'd1;
  assign idx   = 2'({1'b0, i_q} + j_q);
  assign idx1  = idx + 2'd1;

  always_comb begin
    case (j_q)
      2'd0:    p_sel = p_q[0];
      2'd1:    p_sel = p_q[1];
      default: p_sel = p_q[2];
    endcase
  end

  always_comb begin
    unique case (op_q)
      OP_P: begin
        x_last = 1'b1;
        y_last = 2'd1;
        x_limb = i_q ? limb_t'(na_q[AccW-1:LimbW]) : na_q[LimbW-1:0];
        y_limb = j_q[0] ? limb_t'(nb_q[AccW-1:LimbW]) : nb_q[LimbW-1:0];
      end
      OP_D2: begin
        x_last = 1'b1;
        y_last = 2'd1;
        x_limb = i_q ? limb_t'(mag_q[AccW-1:LimbW]) : mag_q[LimbW-1:0];
        y_limb = j_q[0] ? limb_t'(mag_q[AccW-1:LimbW]) : mag_q[LimbW-1:0];
      end
      OP_K: begin
        x_last = 1'b0;
        y_last = 2'd0;
        x_limb = limb_t'(k_val);
        y_limb = limb_t'(k_val);
      end
      default: begin
        x_last = 1'b0;
        y_last = 2'd2;
        x_limb = kk_q;
        y_limb = p_sel;
      end
    endcase
  end

  assign t_sum = prod_t'(acc_q[idx]) + mul_prod_i + prod_t'(carry_q);
  assign diff  = {1'b0, r_q[j_q]} - {1'b0, acc_q[j_q]} - (LimbW+1)'(borrow_q);
  assign cmp_end = (j_q == 2'd3);
  assign c_new = diff[LimbW] ? c_q : cand;

  assign term  = {18'd0, mul_prod_i[LimbW-1:0]};
  assign sterm = neg_ab_q ? (50'd0 - term) : term;
  assign dsum  = {{2{dot_q[AccW-1]}}, dot_q} + sterm;
  always_comb begin
    if (dsum[49:47] == 3'b000 || dsum[49:47] == 3'b111) begin
      dot_next = dsum[AccW-1:0];
    end else if (dsum[49]) begin
      dot_next = DotMin;
    end else begin
      dot_next = DotMax;
    end
  end

  assign nsum_a  = {1'b0, na_q} + (AccW+1)'(mul_prod_i[LimbW-1:0]);
  assign nsum_b  = {1'b0, nb_q} + (AccW+1)'(mul_prod_i[LimbW-1:0]);
  assign na_next = nsum_a[AccW] ? NormMax : nsum_a[AccW-1:0];
  assign nb_next = nsum_b[AccW] ? NormMax : nsum_b[AccW-1:0];
  assign zero_in = (na_q == '0) || (nb_q == '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (in_valid_i) state_d = ST_DOT_MUL;
      ST_DOT_MUL:   state_d = ST_DOT_ADD;
      ST_DOT_ADD:   state_d = ST_NA_ADD;
      ST_NA_ADD:    state_d = ST_NB_ADD;
      ST_NB_ADD:    state_d = last_q ? ST_FIN : ST_IDLE;
      ST_FIN:       state_d = zero_in ? ST_OUT : ST_MUL_ISSUE;
      ST_MUL_ISSUE: state_d = ST_MUL_ADD;
      ST_MUL_ADD: begin
        if (j_q == y_last && i_q == x_last) state_d = ST_MUL_DONE;
        else                                state_d = ST_MUL_ISSUE;
      end
      ST_MUL_DONE:  state_d = (op_q == OP_L) ? ST_CMP : ST_MUL_ISSUE;
      ST_CMP: begin
        if (cmp_end) state_d = (bit_q == '0) ? ST_OUT : ST_MUL_ISSUE;
      end
      ST_OUT:       if (res_ready_i) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    mul_a_o     = '0;
    mul_b_o     = '0;
    unique case (state_q)
      ST_IDLE:    in_ready_o = 1'b1;
      ST_DOT_MUL: begin
        mul_a_o = limb_t'(a_mag_q);
        mul_b_o = limb_t'(b_mag_q);
      end
      ST_DOT_ADD: begin
        mul_a_o = limb_t'(a_mag_q);
        mul_b_o = limb_t'(a_mag_q);
      end
      ST_NA_ADD: begin
        mul_a_o = limb_t'(b_mag_q);
        mul_b_o = limb_t'(b_mag_q);
      end
      ST_MUL_ISSUE: begin
        mul_a_o = x_limb;
        mul_b_o = y_limb;
      end
      ST_OUT:     res_valid_o = 1'b1;
      default: ;
    endcase
  end

  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_P;
      dot_q   <= '0;
      na_q    <= '0;
      nb_q    <= '0;
      i_q     <= 1'b0;
      j_q     <= '0;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_DOT_ADD: dot_q <= dot_next;
        ST_NA_ADD:  na_q  <= na_next;
        ST_NB_ADD:  nb_q  <= nb_next;
        ST_FIN: begin
          op_q <= OP_P;
          i_q  <= 1'b0;
          j_q  <= '0;
        end
        ST_MUL_ADD: begin
          if (j_q == y_last) begin
            j_q <= '0;
            if (i_q != x_last) i_q <= 1'b1;
          end else begin
            j_q <= j_q + 2'd1;
          end
        end
        ST_MUL_DONE: begin
          i_q <= 1'b0;
          j_q <= '0;
          unique case (op_q)
            OP_P:  op_q <= OP_D2;
            OP_D2: begin
              op_q  <= OP_K;
              bit_q <= TopBit;
            end
            OP_K:  op_q <= OP_L;
            default: ;
          endcase
        end
        ST_CMP: begin
          if (cmp_end && bit_q != '0) begin
            bit_q <= bit_q - 4'd1;
            op_q  <= OP_K;
            i_q   <= 1'b0;
            j_q   <= '0;
          end else begin
            j_q <= j_q + 2'd1;
          end
        end
        ST_OUT: begin
          if (res_ready_i) begin
            dot_q <= '0;
            na_q  <= '0;
            nb_q  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        a_mag_q  <= in_data_i.a_value[15] ? (16'd0 - $unsigned(in_data_i.a_value))
                                          : $unsigned(in_data_i.a_value);
        b_mag_q  <= in_data_i.b_value[15] ? (16'd0 - $unsigned(in_data_i.b_value))
                                          : $unsigned(in_data_i.b_value);
        neg_ab_q <= in_data_i.a_value[15] ^ in_data_i.b_value[15];
        last_q   <= in_data_i.last;
      end
      ST_FIN: begin
        mag_q   <= dot_q[AccW-1] ? (AccW'(0) - dot_q) : dot_q;
        neg_q   <= dot_q[AccW-1];
        acc_q   <= '0;
        carry_q <= '0;
        res_q   <= '{similarity: '0, zero_norm: 1'b1};
      end
      ST_MUL_ADD: begin
        acc_q[idx] <= t_sum[LimbW-1:0];
        if (j_q == y_last) begin
          acc_q[idx1] <= t_sum[2*LimbW-1:LimbW];
          carry_q     <= '0;
        end else begin
          carry_q <= t_sum[2*LimbW-1:LimbW];
        end
      end
      ST_MUL_DONE: begin
        unique case (op_q)
          OP_P:  p_q  <= acc_q[2:0];
          OP_D2: begin
            r_q <= {acc_q[2], acc_q[1], acc_q[0], limb_t'(0)};
            c_q <= '0;
          end
          OP_K:  kk_q <= acc_q[0];
          default: ;
        endcase
        if (op_q == OP_L) begin
          borrow_q <= 1'b0;
        end else begin
          acc_q   <= '0;
          carry_q <= '0;
        end
      end
      ST_CMP: begin
        borrow_q <= diff[LimbW];
        if (cmp_end) begin
          c_q     <= c_new;
          acc_q   <= '0;
          carry_q <= '0;
          res_q.zero_norm  <= 1'b0;
          res_q.similarity <= neg_q ? $signed(16'd0 - {1'b0, c_new})
                                    : $signed({1'b0, c_new});
        end
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/core/cosine_similarity_stream.sv
// ---------------------------------------------------------------------------
// Cosine similarity stream
// Streams element pairs of two Q1.15 vectors and returns their Q1.15 cosine.
// ---------------------------------------------------------------------------
// Input channel: one word per element pair (a_value, b_value, last). The
// word ending a vector carries last = 1; a one-word vector is allowed.
// Output channel: one word per vector (similarity, zero_norm), rounded to
// nearest and saturated to +-32767; zero_norm = 1 with similarity 0 when
// either vector is all zeros. Accumulators clear once the result is out.
// Each element passes through the shared 32x32 multiplier as three products,
// each issued then accumulated; no new element is taken until it is done.
// After the last element the block forms the exact norm and dot products,
// then 15 result bits, each by a square, a limb product and a four-limb
// compare, all serialized through the same multiplier.
// Reset clears the accumulators and empties the output register.
// The result sits in an output register; while the receiver stalls, the
// block still takes the elements of the next vector and only holds before
// delivering the next result.
// ---------------------------------------------------------------------------
module cosine_similarity_stream import csim_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  limb_t mul_a, mul_b;
  prod_t mul_prod;
  logic  res_valid, res_ready;
  out_t  res;
  logic  out_valid_q;
  out_t  out_data_q;

  csim_mul u_mul (
    .clk_i  (clk_i),
    .op_a_i (mul_a),
    .op_b_i (mul_b),
    .prod_o (mul_prod)
  );

  csim_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mul_a_o     (mul_a),
    .mul_b_o     (mul_b),
    .mul_prod_i  (mul_prod)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> rtl/core/csim_chk.sv
// ---------------------------------------------------------------------------
// Cosine similarity port checker
// Port-level assertions on the cosine similarity stream, bound to the top.
// ---------------------------------------------------------------------------
module csim_chk import csim_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input in_t  in_data_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result word changed or dropped");

  a_zero_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.zero_norm |-> out_data_o.similarity == 16'sd0)
    else $error("zero norm word with nonzero similarity");

  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.similarity != -16'sd32768)
    else $error("similarity below saturation limit");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while previous word still in work");

endmodule

bind cosine_similarity_stream csim_chk u_csim_chk (.*);

>>> bench/cosine_checker.sv
// ---------------------------------------------------------------------------
// Cosine similarity checker
// Watches both channels of the cosine similarity stream, tracks the dot
// product and squared norms of each accepted element pair, predicts the
// rounded Q1.15 cosine on each closing word, and compares it against the
// output words in order.
// ---------------------------------------------------------------------------
module cosine_checker import csim_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  in_t  in_data_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  out_t out_data_i,
  output int   err_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint DotHi = longint'($signed(DotMax));
  localparam longint DotLo = longint'($signed(DotMin));

  longint      dot_acc;
  logic [47:0] norm_a_acc;
  logic [47:0] norm_b_acc;
  out_t        expected_cosines[$];
  out_t        oldest;
  int          mismatch_count;

  function automatic logic [14:0] cosine_magnitude(logic [47:0] mag, logic [47:0] na,
                                                   logic [47:0] nb);
    logic [127:0] norm_prod;
    logic [127:0] dot_sq;
    logic [127:0] lhs;
    logic [31:0]  lo;
    logic [31:0]  hi;
    logic [31:0]  mid;
    logic [31:0]  k;
    norm_prod = 128'(na) * 128'(nb);
    dot_sq    = (128'(mag) * 128'(mag)) << 32;
    lo = 0;
    hi = 32767;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      k   = 2 * mid - 1;
      lhs = 128'(k) * 128'(k) * norm_prod;
      if (lhs <= dot_sq) lo = mid;
      else hi = mid - 1;
    end
    return lo[14:0];
  endfunction

  function automatic out_t cosine_of(longint dot, logic [47:0] na, logic [47:0] nb);
    out_t        r;
    logic [47:0] mag;
    logic [15:0] m;
    if (na == 0 || nb == 0) begin
      r.similarity = '0;
      r.zero_norm  = 1'b1;
    end else begin
      mag = (dot < 0) ? 48'(-dot) : 48'(dot);
      m   = {1'b0, cosine_magnitude(mag, na, nb)};
      r.similarity = (dot < 0) ? -m : m;
      r.zero_norm  = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [47:0] norm_add(logic [47:0] acc, logic signed [15:0] x);
    longint     xl;
    logic [48:0] s;
    xl = x;
    s  = 49'(acc) + 49'(xl * xl);
    if (s > 49'(NormMax)) s = 49'(NormMax);
    return s[47:0];
  endfunction

  function automatic longint dot_add(longint acc, logic signed [15:0] a,
                                     logic signed [15:0] b);
    longint d;
    d = acc + longint'(a) * longint'(b);
    if (d > DotHi) d = DotHi;
    if (d < DotLo) d = DotLo;
    return d;
  endfunction

  task automatic flag_mismatch(string what, out_t want, out_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t cosine %s: expected sim %0d zn %0b, got sim %0d zn %0b", $realtime,
               what, want.similarity, want.zero_norm, got.similarity, got.zero_norm);
  endtask

  initial mismatch_count = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_acc    = 0;
      norm_a_acc = '0;
      norm_b_acc = '0;
      expected_cosines.delete();
      pending_o   <= 0;
      err_count_o <= mismatch_count;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_cosines.size() == 0) begin
          flag_mismatch("word with nothing pending", '0, out_data_i);
        end else begin
          oldest = expected_cosines.pop_front();
          if (oldest.similarity !== out_data_i.similarity ||
              oldest.zero_norm !== out_data_i.zero_norm)
            flag_mismatch("mismatch", oldest, out_data_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        dot_acc    = dot_add(dot_acc, in_data_i.a_value, in_data_i.b_value);
        norm_a_acc = norm_add(norm_a_acc, in_data_i.a_value);
        norm_b_acc = norm_add(norm_b_acc, in_data_i.b_value);
        if (in_data_i.last) begin
          expected_cosines.push_back(cosine_of(dot_acc, norm_a_acc, norm_b_acc));
          dot_acc    = 0;
          norm_a_acc = '0;
          norm_b_acc = '0;
        end
      end
      pending_o   <= expected_cosines.size();
      err_count_o <= mismatch_count;
    end
  end

endmodule

>>> bench/tb_cosine_similarity_stream.sv
// ---------------------------------------------------------------------------
// Cosine similarity stream testbench
// Drives element pairs with random gaps and output stalls: a directed set
// of extreme, zero-norm and single-element vectors, then random vectors of
// mixed length and content. The checker beside the block predicts and
// compares each cosine.
// ---------------------------------------------------------------------------
module tb_cosine_similarity_stream import csim_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 4_000_000;
  localparam int          RandomPairs = 1680;
  localparam int          SettleCycles = 300;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;
  int   err_count;
  int   pending;
  int   pairs_sent;
  bit   sender_rush;

  cosine_similarity_stream DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  cosine_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic send_pair(logic signed [15:0] a, logic signed [15:0] b, logic last);
    in_t word;
    int  gap;
    word.a_value = a;
    word.b_value = b;
    word.last    = last;
    gap = sender_rush ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= word;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pairs_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] draw_element(int kind);
    case (kind)
      0: return 16'($urandom);
      1: return 16'(int'($urandom_range(0, 16)) - 8);
      default: begin
        case ($urandom_range(0, 5))
          0: return 16'sh8000;
          1: return 16'sh8001;
          2: return 16'shFFFF;
          3: return 16'sh0000;
          4: return 16'sh0001;
          default: return 16'sh7FFF;
        endcase
      end
    endcase
  endfunction

  task automatic send_random_vector();
    int                 len;
    int                 pick;
    int                 relation;
    int                 kind_a;
    int                 kind_b;
    logic signed [15:0] a;
    logic signed [15:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 50) len = $urandom_range(1, 4);
    else if (pick < 85) len = $urandom_range(5, 16);
    else if (pick < 98) len = $urandom_range(17, 64);
    else len = $urandom_range(65, 512);
    relation = $urandom_range(0, 9);
    kind_a   = $urandom_range(0, 2);
    kind_b   = $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) sender_rush = !sender_rush;
    for (int i = 0; i < len; i++) begin
      a = draw_element(kind_a);
      case (relation)
        1: b = a;
        2: b = -a;
        3: b = a + draw_element(1);
        4: begin
          a = '0;
          b = draw_element(kind_b);
        end
        5: b = '0;
        default: b = draw_element(kind_b);
      endcase
      send_pair(a, b, i == len - 1);
    end
  endtask

  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("** cosine_similarity_stream: FAILED **");
    $finish;
  end

  initial begin
    int  stall;
    bit  drain_rush;
    drain_rush = 1'b0;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 7) == 0) drain_rush = !drain_rush;
      stall = drain_rush ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  initial begin
    int  target;
    bit  pressure_done;
    pairs_sent    = 0;
    sender_rush   = 1'b0;
    pressure_done = 1'b0;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_pair(16'sh7FFF, 16'sh7FFF, 1'b1);
    send_pair(16'sh8000, 16'sh8000, 1'b1);
    send_pair(16'sh8000, 16'sh7FFF, 1'b1);
    send_pair(16'sh7FFF, 16'sh8000, 1'b1);
    send_pair(16'sh0000, 16'sh0005, 1'b1);
    send_pair(16'sh0005, 16'sh0000, 1'b1);
    send_pair(16'sh0000, 16'sh0000, 1'b1);
    send_pair(16'sh0001, 16'shFFFF, 1'b1);
    send_pair(16'sh0001, 16'sh0000, 1'b0);
    send_pair(16'sh0000, 16'sh0001, 1'b1);
    send_pair(16'sh7FFF, 16'sh8000, 1'b0);
    send_pair(16'sh8000, 16'sh7FFF, 1'b1);
    send_pair(16'sh0000, 16'sh0003, 1'b0);
    send_pair(16'sh0000, 16'shFFF9, 1'b1);
    send_pair(16'sh0003, 16'sh0004, 1'b0);
    send_pair(16'sh0004, 16'shFFFD, 1'b1);
    send_pair(16'sh5A82, 16'sh7FFF, 1'b0);
    send_pair(16'sh5A82, 16'sh0000, 1'b1);
    send_pair(16'sh7FFF, 16'sh0001, 1'b0);
    send_pair(16'sh0001, 16'sh7FFF, 1'b1);

    target = pairs_sent + RandomPairs;
    while (pairs_sent < target) begin
      if (!pressure_done && pairs_sent >= target - RandomPairs / 2) begin
        wait_drained();
        pressure_done = 1'b1;
      end
      send_random_vector();
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (err_count == 0 && pending == 0)
      $display("** cosine_similarity_stream: PASSED **");
    else
      $display("** cosine_similarity_stream: FAILED **");
    $finish;
  end

endmodule
